@@ hw/rtl/signed_mul_div_flags_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the signed multiply/divide unit
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_MUL_DIV_FLAGS_UNIT_ASSERT_SVH
`define SIGNED_MUL_DIV_FLAGS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SMDF_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");
`define SMDF_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");
`else
`define SMDF_ASSERT(lbl, cond)
`define SMDF_ASSERT_IMP(lbl, pre, post)
`endif
`endif

@@ hw/rtl/smdf_pkg.sv @@
// ----------------------------------------------------------------------------
// smdf_pkg
// Shared types and constants of the signed multiply/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none
package smdf_pkg;

  localparam int unsigned DivStages   = 8;
  localparam int unsigned BitsPerStep = 32 / DivStages;

  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagV = 1;
  localparam int unsigned FlagC = 0;

  typedef enum logic [1:0] {
    KIND_MUL  = 2'd0,
    KIND_DIVB = 2'd1,
    KIND_DIVW = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] q_in;
    logic [3:0]  flags_in;
    logic        trap;
    logic        neg_q;
    logic        neg_r;
    logic [31:0] prod;
    logic [15:0] dvs;
    logic [15:0] rem;
    logic [31:0] quot;
  } stage_t;

endpackage
`default_nettype wire

@@ hw/rtl/smdf_prep.sv @@
// ----------------------------------------------------------------------------
// smdf_prep
// Entry stage: decode, zero-divisor check, magnitudes, 16x16 product.
// ----------------------------------------------------------------------------
`default_nettype none
module smdf_prep (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire logic [1:0]     kind_i,
  input  wire logic [31:0]    q_in_i,
  input  wire logic [15:0]    operand_i,
  input  wire logic [3:0]     flags_in_i,
  output logic                valid_o,
  output smdf_pkg::stage_t    stage_o
);
  import smdf_pkg::*;

  logic        valid_q;
  stage_t      stage_d, stage_q;
  logic [31:0] dividend;
  logic [15:0] divisor;

  always_comb begin
    stage_d          = '0;
    stage_d.kind     = kind_e'(kind_i);
    stage_d.q_in     = q_in_i;
    stage_d.flags_in = flags_in_i;
    stage_d.prod     = 32'($signed({{16{q_in_i[31]}}, q_in_i[31:16]}) *
                           $signed({{16{operand_i[15]}}, operand_i}));
    if (kind_e'(kind_i) == KIND_DIVB) begin
      dividend     = {{16{q_in_i[31]}}, q_in_i[31:16]};
      divisor      = {{8{operand_i[7]}}, operand_i[7:0]};
      stage_d.trap = (operand_i[7:0] == 8'd0);
    end else begin
      dividend     = q_in_i;
      divisor      = operand_i;
      stage_d.trap = (kind_e'(kind_i) == KIND_DIVW) && (operand_i == 16'd0);
    end
    stage_d.neg_r = dividend[31];
    stage_d.neg_q = dividend[31] ^ divisor[15];
    stage_d.quot  = dividend[31] ? 32'(-dividend) : dividend;
    stage_d.dvs   = divisor[15] ? 16'(-divisor) : divisor;
    stage_d.rem   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
`default_nettype wire

@@ hw/rtl/smdf_div_stage.sv @@
// ----------------------------------------------------------------------------
// smdf_div_stage
// One registered restoring-division stage retiring a few quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none
module smdf_div_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire smdf_pkg::stage_t stage_i,
  output logic                valid_o,
  output smdf_pkg::stage_t    stage_o
);
  import smdf_pkg::*;

  logic   valid_q;
  stage_t stage_d, stage_q;
  logic [16:0] part;

  always_comb begin
    stage_d = stage_i;
    part    = '0;
    for (int i = 0; i < int'(BitsPerStep); i++) begin
      part = {stage_d.rem, stage_d.quot[31]};
      stage_d.quot = {stage_d.quot[30:0], 1'b0};
      if (part >= {1'b0, stage_d.dvs}) begin
        part = part - {1'b0, stage_d.dvs};
        stage_d.quot[0] = 1'b1;
      end
      stage_d.rem = part[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
`default_nettype wire

@@ hw/rtl/smdf_fix.sv @@
// ----------------------------------------------------------------------------
// smdf_fix
// Result stage logic: signs, overflow rules, flags and register restore.
// ----------------------------------------------------------------------------
`default_nettype none
module smdf_fix (
  input  wire smdf_pkg::stage_t stage_i,
  output logic [31:0]         q_o,
  output logic [3:0]          flags_o,
  output logic                trap_o
);
  import smdf_pkg::*;

  logic [31:0]        qs;
  logic [15:0]        rs;
  logic signed [31:0] qt_w;
  logic signed [15:0] qt_b;
  logic               soft_ovf, hard;
  logic [15:0]        d_new;

  always_comb begin
    qs       = stage_i.neg_q ? 32'(-stage_i.quot) : stage_i.quot;
    rs       = stage_i.neg_r ? 16'(-stage_i.rem) : stage_i.rem;
    qt_w     = $signed(qs);
    qt_b     = $signed(qs[15:0]);
    q_o      = stage_i.q_in;
    flags_o  = stage_i.flags_in;
    trap_o   = 1'b0;
    soft_ovf = 1'b0;
    hard     = 1'b0;
    d_new    = '0;
    case (stage_i.kind)
      KIND_MUL: begin
        q_o = stage_i.prod;
        flags_o = {stage_i.prod[31], stage_i.prod == 32'd0, 2'b00};
      end
      KIND_DIVB: begin
        if (stage_i.trap) begin
          trap_o = 1'b1;
        end else begin
          soft_ovf = (qt_b > 16'sd128) || (qt_b < -16'sd127);
          hard     = (qt_b > 16'sd256) || (qt_b < -16'sd255);
          flags_o[FlagN] = qs[7];
          flags_o[FlagZ] = (qs[7:0] == 8'd0);
          flags_o[FlagC] = qs[0];
          flags_o[FlagV] = soft_ovf;
          d_new = {rs[7:0], qs[7:0]};
          if (hard) begin
            flags_o[FlagN] = stage_i.q_in[31];
            flags_o[FlagZ] = (stage_i.q_in[31:16] == 16'd0);
            d_new = stage_i.q_in[31] ? 16'(-stage_i.q_in[31:16]) : stage_i.q_in[31:16];
          end
          q_o = {d_new, stage_i.q_in[15:0]};
        end
      end
      KIND_DIVW: begin
        if (stage_i.trap) begin
          trap_o = 1'b1;
        end else begin
          soft_ovf = (qt_w > 32'sd32768) || (qt_w < -32'sd32767);
          hard     = (qt_w > 32'sd65536) || (qt_w < -32'sd65535);
          flags_o[FlagN] = qs[15] | (hard & stage_i.q_in[31]);
          flags_o[FlagZ] = (qs[15:0] == 16'd0);
          flags_o[FlagC] = qs[0];
          flags_o[FlagV] = soft_ovf;
          q_o = hard ? stage_i.q_in : {rs, qs[15:0]};
        end
      end
      default: begin
        q_o = stage_i.q_in;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/signed_mul_div_flags_unit.sv @@
// Data path: the entry register, the eight division stages, then the output register.
// Throughput: one item per cycle while the receiver does not stall; the eight-stage
//   division pipeline, four quotient bits per stage, sets the depth.
// Reset: rst_ni clears all valid bits asynchronously; payload is not reset.
// A stalled stage holds; bubbles behind it are squeezed out.
// ----------------------------------------------------------------------------
// signed_mul_div_flags_unit
// Pipelined signed multiply, byte divide and word divide with N/Z/V/C flags.
// ----------------------------------------------------------------------------
`default_nettype none
`include "signed_mul_div_flags_unit_assert.svh"
module signed_mul_div_flags_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] q_in_i,
  input  wire logic [15:0] operand_i,
  input  wire logic [3:0]  flags_in_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      q_out_o,
  output logic [3:0]       flags_out_o,
  output logic             div_zero_trap_o
);
  import smdf_pkg::*;

  // Stage 0 is the entry register, stages 1..DivStages the divider.
  logic   vld [0:DivStages];
  stage_t stg [0:DivStages];
  logic   en  [0:DivStages];
  logic   out_en;

  logic        out_valid_q;
  logic [31:0] q_out_q;
  logic [3:0]  flags_out_q;
  logic        trap_q;

  logic [31:0] fix_q;
  logic [3:0]  fix_flags;
  logic        fix_trap;

  // Advance a stage when it is empty or the one after it advances.
  assign out_en = !out_valid_q || !stall_i;
  always_comb begin
    en[DivStages] = !vld[DivStages] || out_en;
    for (int k = int'(DivStages) - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k + 1];
    end
  end
  assign stall_o = !en[0];

  smdf_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en[0]),
    .valid_i    (valid_i),
    .kind_i     (kind_i),
    .q_in_i     (q_in_i),
    .operand_i  (operand_i),
    .flags_in_i (flags_in_i),
    .valid_o    (vld[0]),
    .stage_o    (stg[0])
  );

  for (genvar g = 1; g <= int'(DivStages); g++) begin : g_div
    smdf_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[g]),
      .valid_i (vld[g - 1]),
      .stage_i (stg[g - 1]),
      .valid_o (vld[g]),
      .stage_o (stg[g])
    );
  end

  smdf_fix u_fix (
    .stage_i (stg[DivStages]),
    .q_o     (fix_q),
    .flags_o (fix_flags),
    .trap_o  (fix_trap)
  );

  // Output register: holds a result while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= vld[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      q_out_q     <= fix_q;
      flags_out_q <= fix_flags;
      trap_q      <= fix_trap;
    end
  end

  assign valid_o         = out_valid_q;
  assign q_out_o         = q_out_q;
  assign flags_out_o     = flags_out_q;
  assign div_zero_trap_o = trap_q;

  `SMDF_ASSERT_IMP(a_stall_needs_full_out, stall_o, out_valid_q && stall_i)
  `SMDF_ASSERT_IMP(a_mul_clears_vc, vld[DivStages] && stg[DivStages].kind == KIND_MUL,
                   fix_flags[FlagV] == 1'b0 && fix_flags[FlagC] == 1'b0 && !fix_trap)
  `SMDF_ASSERT_IMP(a_trap_keeps_state, vld[DivStages] && fix_trap,
                   fix_q == stg[DivStages].q_in && fix_flags == stg[DivStages].flags_in)

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signed multiply/divide unit: a queue-fed driver
// pushes multiply, byte divide, word divide and no-op items, a monitor compares
// each result against a local flag/quotient predictor, with random idling
// on both sides.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import smdf_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] q;
    logic [15:0] opw;
    logic [3:0]  fl;
  } op_item_t;

  typedef struct packed {
    logic [31:0] q;
    logic [3:0]  fl;
    logic        trap;
  } op_result_t;

  localparam int unsigned Latency   = 10;
  localparam int unsigned CycleCap  = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [1:0]  kind_i;
  logic [31:0] q_in_i;
  logic [15:0] operand_i;
  logic [3:0]  flags_in_i;
  logic        valid_o;
  logic        stall_i;
  logic [31:0] q_out_o;
  logic [3:0]  flags_out_o;
  logic        div_zero_trap_o;

  op_item_t   pending_q[$];
  op_result_t expected_q[$];
  int         errors = 0;
  int         send_idle_pct = 24;
  int         recv_idle_pct = 74;
  bit         in_acc = 0;
  int unsigned cycles = 0;

  signed_mul_div_flags_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Compute the expected Q, flags and trap of one operation.
  function automatic op_result_t predict_op(op_item_t it);
    op_result_t  r;
    logic [15:0] d;
    logic [15:0] w;
    longint      dv;
    longint      dr;
    longint      qt;
    longint      rm;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [15:0] nw;
    logic [15:0] nd;
    r.q = it.q;
    r.fl = it.fl;
    r.trap = 1'b0;
    d = it.q[31:16];
    w = it.q[15:0];
    case (it.kind)
      KIND_MUL: begin
        dv = longint'($signed(d)) * longint'($signed(it.opw));
        r.q = dv[31:0];
        r.fl = '0;
        r.fl[FlagN] = r.q[31];
        r.fl[FlagZ] = (r.q == 0);
      end
      KIND_DIVB: begin
        if (it.opw[7:0] == 0) begin
          r.trap = 1'b1;
        end else begin
          dv = $signed(d);
          dr = $signed(it.opw[7:0]);
          qt = dv / dr;
          qt = longint'($signed(qt[15:0]));
          rm = dv % dr;
          a = rm[7:0];
          b = qt[7:0];
          r.fl[FlagN] = b[7];
          r.fl[FlagZ] = (b == 0);
          r.fl[FlagC] = b[0];
          d = {a, b};
          if (qt > 128 || qt < -127) begin
            r.fl[FlagV] = 1'b1;
            if (qt > 256 || qt < -255) begin
              r.fl[FlagN] = (dv < 0);
              r.fl[FlagZ] = (dv == 0);
              rm = (dv < 0) ? -dv : dv;
              d = rm[15:0];
            end
          end else begin
            r.fl[FlagV] = 1'b0;
          end
          r.q = {d, w};
        end
      end
      KIND_DIVW: begin
        if (it.opw == 0) begin
          r.trap = 1'b1;
        end else begin
          dv = $signed(it.q);
          dr = $signed(it.opw);
          qt = dv / dr;
          qt = longint'($signed(qt[31:0]));
          rm = (dv == -64'sd2147483648 && dr == -1) ? 0 : dv % dr;
          nw = qt[15:0];
          nd = rm[15:0];
          r.fl[FlagN] = nw[15];
          r.fl[FlagZ] = (nw == 0);
          r.fl[FlagC] = nw[0];
          r.q = {nd, nw};
          if (qt > 32768 || qt < -32767) begin
            r.fl[FlagV] = 1'b1;
            if (qt > 65536 || qt < -65535) begin
              if (dv < 0) r.fl[FlagN] = 1'b1;
              else if (dv == 0) r.fl[FlagZ] = 1'b1;
              r.q = it.q;
            end
          end else begin
            r.fl[FlagV] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic op_item_t make_item(logic [1:0] k, logic [31:0] q, logic [15:0] o,
                                         logic [3:0] f);
    op_item_t it;
    it.kind = k;
    it.q = q;
    it.opw = o;
    it.fl = f;
    return it;
  endfunction

  // Bias divisors toward small magnitudes so results stay in range often.
  function automatic op_item_t rand_item();
    op_item_t it;
    int sel;
    it.kind = ($urandom_range(0, 19) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
    it.q = $urandom();
    it.fl = 4'($urandom());
    sel = $urandom_range(0, 9);
    if (sel < 4) it.opw = $urandom();
    else if (sel < 8) begin
      it.opw = 16'($urandom_range(1, 300));
      if ($urandom_range(0, 1)) it.opw = -it.opw;
    end else if (sel == 8) it.opw = 16'($urandom_range(0, 1) ? 0 : 16'hff00);
    else it.opw = 16'hffff;
    if ($urandom_range(0, 3) == 0) it.q[31:16] = {16{it.q[15]}};
    return it;
  endfunction

  // Driver: present the head of the pending queue; advance on acceptance,
  // which the monitor samples at the rising edge.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i    <= 1'b0;
      stall_i    <= 1'b0;
      kind_i     <= '0;
      q_in_i     <= '0;
      operand_i  <= '0;
      flags_in_i <= '0;
    end else begin
      if (in_acc) pending_q.pop_front();
      if (!(valid_i && !in_acc)) begin
        if (pending_q.size() > 0 && ($urandom_range(0, 99) >= send_idle_pct)) begin
          kind_i     <= pending_q[0].kind;
          q_in_i     <= pending_q[0].q;
          operand_i  <= pending_q[0].opw;
          flags_in_i <= pending_q[0].fl;
          valid_i    <= 1'b1;
        end else begin
          valid_i <= 1'b0;
        end
      end
      stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Record expectations at input acceptance, check results at output.
  always @(posedge clk_i) begin
    op_result_t exp_r;
    if (rst_ni) begin
      cycles <= cycles + 1;
      in_acc <= valid_i && !stall_o;
      if (valid_i && !stall_o)
        expected_q.push_back(predict_op(make_item(kind_i, q_in_i, operand_i, flags_in_i)));
      if (valid_o && !stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no expectation waiting");
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (q_out_o !== exp_r.q) begin
            $error("q_out: expected %h actual %h", exp_r.q, q_out_o);
            errors++;
          end
          if (flags_out_o !== exp_r.fl) begin
            $error("flags_out: expected %h actual %h", exp_r.fl, flags_out_o);
            errors++;
          end
          if (div_zero_trap_o !== exp_r.trap) begin
            $error("div_zero_trap: expected %b actual %b", exp_r.trap, div_zero_trap_o);
            errors++;
          end
        end
      end
    end else begin
      in_acc <= 1'b0;
    end
  end

  // Time limit: end the run well past the slowest correct schedule.
  always @(posedge clk_i) begin
    if (cycles > CycleCap) begin
      $display("signed_mul_div_flags_unit regression: fail");
      $finish;
    end
  end

  task automatic wait_empty();
    while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: extremes, every kind, zero divisors, overflow corners.
    pending_q.push_back(make_item(KIND_MUL,  32'h7fff_0000, 16'h7fff, 4'h0));
    pending_q.push_back(make_item(KIND_MUL,  32'h8000_ffff, 16'h8000, 4'hf));
    pending_q.push_back(make_item(KIND_MUL,  32'h0000_1234, 16'hffff, 4'h5));
    pending_q.push_back(make_item(KIND_MUL,  32'hffff_0000, 16'h0001, 4'ha));
    pending_q.push_back(make_item(KIND_DIVB, 32'h1234_5678, 16'hff00, 4'h3));
    pending_q.push_back(make_item(KIND_DIVW, 32'h8000_0000, 16'h0000, 4'hc));
    pending_q.push_back(make_item(KIND_DIVB, 32'h8000_abcd, 16'h00ff, 4'h0));
    pending_q.push_back(make_item(KIND_DIVW, 32'h8000_0000, 16'hffff, 4'h0));
    pending_q.push_back(make_item(KIND_DIVB, 32'h7fff_0000, 16'h0080, 4'hf));
    pending_q.push_back(make_item(KIND_DIVB, 32'h0080_0000, 16'h0001, 4'h0));
    pending_q.push_back(make_item(KIND_DIVB, 32'h0081_0000, 16'h0001, 4'h0));
    pending_q.push_back(make_item(KIND_DIVB, 32'h0101_0000, 16'h0001, 4'h0));
    pending_q.push_back(make_item(KIND_DIVB, 32'hff00_0000, 16'h00ff, 4'h0));
    pending_q.push_back(make_item(KIND_DIVB, 32'h0000_ffff, 16'h0005, 4'hf));
    pending_q.push_back(make_item(KIND_DIVW, 32'h0000_8000, 16'h0001, 4'h0));
    pending_q.push_back(make_item(KIND_DIVW, 32'h0000_8001, 16'h0001, 4'h0));
    pending_q.push_back(make_item(KIND_DIVW, 32'h0001_0001, 16'h0001, 4'h0));
    pending_q.push_back(make_item(KIND_DIVW, 32'hffff_0000, 16'hffff, 4'h0));
    pending_q.push_back(make_item(KIND_DIVW, 32'h7fff_ffff, 16'h7fff, 4'hf));
    pending_q.push_back(make_item(KIND_DIVW, 32'h0000_0000, 16'h8000, 4'h9));
    pending_q.push_back(make_item(KIND_NONE, 32'hdead_beef, 16'h0000, 4'h6));
    pending_q.push_back(make_item(KIND_NONE, 32'hffff_ffff, 16'hffff, 4'hf));
    wait_empty();

    // Pressure: hold the sender until the pipe has drained.
    repeat (180) pending_q.push_back(rand_item());
    wait_empty();
    send_idle_pct = 74;
    recv_idle_pct = 24;
    repeat (180) pending_q.push_back(rand_item());
    wait_empty();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (190) pending_q.push_back(rand_item());
    wait_empty();
    repeat (Latency * 3) @(posedge clk_i);

    if (errors == 0) begin
      $display("signed_mul_div_flags_unit regression: pass");
    end else begin
      $display("signed_mul_div_flags_unit regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ signed_mul_div_flags_unit.f @@
+incdir+hw/rtl
hw/rtl/smdf_pkg.sv
hw/rtl/smdf_prep.sv
hw/rtl/smdf_div_stage.sv
hw/rtl/smdf_fix.sv
hw/rtl/signed_mul_div_flags_unit.sv
test/tb_top.sv
